// ===== rtl/core/gcmw_pkg.sv =====
package gcmw_pkg;

  // fixed field widths
  localparam int COORD_W   = 32;
  localparam int LEN_W     = 31;
  localparam int CELL_W    = 10;
  localparam int CORNER_W  = 3;
  localparam int REG_IDX_W = 3;
  localparam int MAX_AXES  = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [CELL_W-1:0]         cell_t;
  typedef logic [CORNER_W-1:0]       corner_t;
  typedef logic [REG_IDX_W-1:0]      reg_idx_t;

  // register map
  localparam reg_idx_t REG_ORIGIN_X   = 3'd0;
  localparam reg_idx_t REG_ORIGIN_Y   = 3'd1;
  localparam reg_idx_t REG_ORIGIN_Z   = 3'd2;
  localparam reg_idx_t REG_CELL_LEN_X = 3'd3;
  localparam reg_idx_t REG_CELL_LEN_Y = 3'd4;
  localparam reg_idx_t REG_CELL_LEN_Z = 3'd5;

  localparam coord_t ORIGIN_RESET = '0;
  localparam len_t   LEN_RESET    = 31'd65536;

endpackage

// ===== rtl/core/gcmw_lane.sv =====
module gcmw_lane import gcmw_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int AXIS_CELLS = 1024
) (
  input  logic           clk,
  input  coord_t         point,
  input  coord_t         origin,
  input  len_t           cell_len,
  input  cell_t          cell_idx,
  output logic [FRAC_BITS:0] coord
);

  localparam int NUM_W  = COORD_W + FRAC_BITS;
  localparam int CIDX_W = $clog2(AXIS_CELLS);
  localparam int CMP_W  = ((CELL_W > CIDX_W) ? CELL_W : CIDX_W) + 1;
  localparam logic [CMP_W-1:0] CELL_MAX = CMP_W'(AXIS_CELLS - 1);
  localparam logic [NUM_W:0]   ONE_V    = (NUM_W+1)'(1) << FRAC_BITS;

  logic [COORD_W:0]     diff;
  len_t                 len_eff;
  logic [CMP_W-1:0]     cell_ext;
  logic [CMP_W-1:0]     cell_sat;

  // per-stage divider state
  logic [NUM_W-1:0]  acc_q  [0:NUM_W];
  len_t              rem_q  [0:NUM_W-1];
  len_t              len_q  [0:NUM_W-1];
  logic [CIDX_W-1:0] cell_q [0:NUM_W];
  logic              neg_q  [0:NUM_W];

  logic [NUM_W-1:0]  cell_shift;
  logic [NUM_W:0]    local_q;

  always_comb begin
    diff     = {point[COORD_W-1], point} - {origin[COORD_W-1], origin};
    len_eff  = (cell_len == '0) ? len_t'(1) : cell_len;
    cell_ext = CMP_W'(cell_idx);
    cell_sat = (cell_ext > CELL_MAX) ? CELL_MAX : cell_ext;
  end

  // input stage: difference, sign, effective length, saturated index
  always_ff @(posedge clk) begin
    acc_q[0]  <= {diff[COORD_W-1:0], {FRAC_BITS{1'b0}}};
    rem_q[0]  <= '0;
    len_q[0]  <= len_eff;
    cell_q[0] <= cell_sat[CIDX_W-1:0];
    neg_q[0]  <= diff[COORD_W];
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [LEN_W:0] trial;
    logic [LEN_W:0] sub;
    logic           ge;

    always_comb begin
      trial = {rem_q[k], acc_q[k][NUM_W-1]};
      sub   = trial - {1'b0, len_q[k]};
      ge    = (trial >= {1'b0, len_q[k]});
    end

    always_ff @(posedge clk) begin
      acc_q[k+1]  <= {acc_q[k][NUM_W-2:0], ge};
      cell_q[k+1] <= cell_q[k];
      neg_q[k+1]  <= neg_q[k];
    end

    if (k < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_q[k+1] <= ge ? sub[LEN_W-1:0] : trial[LEN_W-1:0];
        len_q[k+1] <= len_q[k];
      end
    end
  end

  // subtract the cell offset and clamp to [0, one]
  always_comb begin
    cell_shift = NUM_W'({cell_q[NUM_W], {FRAC_BITS{1'b0}}});
    local_q    = {1'b0, acc_q[NUM_W]} - {1'b0, cell_shift};
  end

  always_ff @(posedge clk) begin
    if (neg_q[NUM_W] || local_q[NUM_W]) begin
      coord <= '0;
    end else if (local_q > ONE_V) begin
      coord <= ONE_V[FRAC_BITS:0];
    end else begin
      coord <= local_q[FRAC_BITS:0];
    end
  end

endmodule

// ===== rtl/core/gcmw_merge.sv =====
module gcmw_merge import gcmw_pkg::*; #(
  parameter int DIMENSION = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic [FRAC_BITS:0] coord [0:DIMENSION-1],
  input  corner_t            corner,
  output logic [FRAC_BITS:0] weight
);

  localparam logic [FRAC_BITS:0] ONE_V = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam int PROD_W = 2 * (FRAC_BITS + 1);

  logic [FRAC_BITS:0] factor [0:DIMENSION-1];
  logic [PROD_W-1:0]  prod_a;
  logic [FRAC_BITS:0] w1;

  // near side takes one minus the coordinate, far side the coordinate
  always_comb begin
    for (int d = 0; d < DIMENSION; d++) begin
      factor[d] = corner[d] ? coord[d] : (ONE_V - coord[d]);
    end
    prod_a = factor[0] * factor[1];
  end

  always_ff @(posedge clk) begin
    w1 <= prod_a[2*FRAC_BITS:FRAC_BITS];
  end

  if (DIMENSION > 2) begin : g_three
    logic [FRAC_BITS:0] f2;
    logic [PROD_W-1:0]  prod_b;

    always_ff @(posedge clk) begin
      f2 <= factor[2];
    end

    always_comb begin
      prod_b = w1 * f2;
    end

    always_ff @(posedge clk) begin
      weight <= prod_b[2*FRAC_BITS:FRAC_BITS];
    end
  end else begin : g_two
    always_ff @(posedge clk) begin
      weight <= w1;
    end
  end

endmodule

// ===== rtl/core/grid_cell_multilinear_weight_top.sv =====
// path: start travels through the axis lanes and the merge multipliers to done
// throughput: one word per cycle, set by the restoring divider in each axis lane,
//   which retires one quotient bit per pipeline stage
// reset: clears the valid pipe, origins to zero and cell lengths to one
// busy is always low and done is a single-cycle strobe; the receiver cannot stall
module grid_cell_multilinear_weight_top import gcmw_pkg::*; #(
  parameter int DIMENSION  = 3,
  parameter int AXIS_CELLS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  coord_t             point_x,
  input  coord_t             point_y,
  input  coord_t             point_z,
  input  cell_t              cell_x,
  input  cell_t              cell_y,
  input  cell_t              cell_z,
  input  corner_t            corner,
  // result side
  output logic               done,
  output logic [FRAC_BITS:0] weight,
  // configuration write port
  input  logic               cfg_we,
  input  reg_idx_t           cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  // lane: input register, one stage per quotient bit, clamp register
  localparam int LANE_LAT = COORD_W + FRAC_BITS + 2;
  // merge: two multiply stages
  localparam int LAT      = LANE_LAT + 2;

  // configuration registers
  coord_t origin   [0:MAX_AXES-1];
  len_t   cell_len [0:MAX_AXES-1];

  coord_t point_a [0:MAX_AXES-1];
  cell_t  cell_a  [0:MAX_AXES-1];

  logic [FRAC_BITS:0] coord [0:DIMENSION-1];

  // valid and corner travel alongside the lanes
  logic [LAT-1:0] vld;
  corner_t        corner_q [0:LANE_LAT-1];

  // the pipeline never stalls, so new words are always taken
  assign busy = 1'b0;

  always_comb begin
    point_a[0] = point_x;
    point_a[1] = point_y;
    point_a[2] = point_z;
    cell_a[0]  = cell_x;
    cell_a[1]  = cell_y;
    cell_a[2]  = cell_z;
  end

  // register writes; indices past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_AXES; d++) begin
        origin[d]   <= ORIGIN_RESET;
        cell_len[d] <= LEN_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin[0]   <= cfg_data;
        REG_ORIGIN_Y:   origin[1]   <= cfg_data;
        REG_ORIGIN_Z:   origin[2]   <= cfg_data;
        REG_CELL_LEN_X: cell_len[0] <= cfg_data[LEN_W-1:0];
        REG_CELL_LEN_Y: cell_len[1] <= cfg_data[LEN_W-1:0];
        REG_CELL_LEN_Z: cell_len[2] <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // one lane per axis, all with the same latency
  for (genvar d = 0; d < DIMENSION; d++) begin : g_lane
    gcmw_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .AXIS_CELLS (AXIS_CELLS)
    ) u_lane (
      .clk      (clk),
      .point    (point_a[d]),
      .origin   (origin[d]),
      .cell_len (cell_len[d]),
      .cell_idx (cell_a[d]),
      .coord    (coord[d])
    );
  end

  // valid pipe, reset clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  // corner delay line, lined up with the lane outputs
  always_ff @(posedge clk) begin
    corner_q[0] <= corner;
    for (int i = 1; i < LANE_LAT; i++) begin
      corner_q[i] <= corner_q[i-1];
    end
  end

  // combine the per-axis factors into the corner weight
  gcmw_merge #(
    .DIMENSION (DIMENSION),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .coord  (coord),
    .corner (corner_q[LANE_LAT-1]),
    .weight (weight)
  );

  assign done = vld[LAT-1];

endmodule

// ===== test/grid_cell_multilinear_weight_check.sv =====
`timescale 1ns / 1ps
module grid_cell_multilinear_weight_check import gcmw_pkg::*; #(
  parameter int DIMENSION  = 3,
  parameter int AXIS_CELLS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  coord_t             point_x,
  input  coord_t             point_y,
  input  coord_t             point_z,
  input  cell_t              cell_x,
  input  cell_t              cell_y,
  input  cell_t              cell_z,
  input  corner_t            corner,
  input  logic               done,
  input  logic [FRAC_BITS:0] weight,
  input  logic               cfg_we,
  input  reg_idx_t           cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output int                 outstanding,
  output int                 failures
);

  localparam longint UNIT = longint'(1) << FRAC_BITS;
  localparam int REPORT_CAP = 200;

  typedef struct {
    int unsigned        seq;
    logic [FRAC_BITS:0] weight;
  } weight_expect_t;

  coord_t         grid_origin [MAX_AXES];
  len_t           grid_span [MAX_AXES];
  weight_expect_t weight_queue [$];
  weight_expect_t head, fresh;
  int unsigned    words_in;

  // clamped local coordinate along one axis, floor division
  function automatic longint local_coord(coord_t p, coord_t o, len_t len, cell_t c);
    longint num, den, quo, idx;
    num = (longint'(p) - longint'(o)) * UNIT;
    den = (len == '0) ? 64'sd1 : longint'(len);
    quo = num / den;
    if ((num % den) != 0 && num < 0) quo -= 1;
    idx = longint'(c);
    if (idx > AXIS_CELLS - 1) idx = AXIS_CELLS - 1;
    quo -= idx * UNIT;
    if (quo < 0) quo = 0;
    else if (quo > UNIT) quo = UNIT;
    return quo;
  endfunction

  function automatic logic [FRAC_BITS:0] corner_weight(coord_t px, coord_t py, coord_t pz,
                                                       cell_t cx, cell_t cy, cell_t cz,
                                                       corner_t cn);
    longint t [MAX_AXES];
    longint w, f;
    t[0] = local_coord(px, grid_origin[0], grid_span[0], cx);
    t[1] = local_coord(py, grid_origin[1], grid_span[1], cy);
    t[2] = local_coord(pz, grid_origin[2], grid_span[2], cz);
    w = UNIT;
    for (int d = 0; d < DIMENSION && d < MAX_AXES; d++) begin
      f = cn[d] ? t[d] : UNIT - t[d];
      w = (w * f) >>> FRAC_BITS;
    end
    return w[FRAC_BITS:0];
  endfunction

  task automatic flag_mismatch(input string what);
    if (failures < REPORT_CAP) $display("weight check: %s at %0t", what, $realtime);
    failures++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      weight_queue.delete();
      for (int a = 0; a < MAX_AXES; a++) begin
        grid_origin[a] = ORIGIN_RESET;
        grid_span[a]   = LEN_RESET;
      end
      words_in    = 0;
      failures    = 0;
      outstanding = 0;
    end else begin
      if (done) begin
        if (weight_queue.size() == 0) begin
          flag_mismatch($sformatf("weight %0d with no word pending", weight));
        end else begin
          head = weight_queue.pop_front();
          if (weight !== head.weight)
            flag_mismatch($sformatf("word %0d weight %0d, predicted %0d",
                                    head.seq, weight, head.weight));
        end
      end
      if (start && !busy) begin
        fresh.seq    = words_in;
        fresh.weight = corner_weight(point_x, point_y, point_z, cell_x, cell_y, cell_z,
                                     corner);
        weight_queue.push_back(fresh);
        words_in++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:   grid_origin[0] = cfg_data;
          REG_ORIGIN_Y:   grid_origin[1] = cfg_data;
          REG_ORIGIN_Z:   grid_origin[2] = cfg_data;
          REG_CELL_LEN_X: grid_span[0]   = cfg_data[LEN_W-1:0];
          REG_CELL_LEN_Y: grid_span[1]   = cfg_data[LEN_W-1:0];
          REG_CELL_LEN_Z: grid_span[2]   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      outstanding = weight_queue.size();
    end
  end

endmodule

// ===== test/grid_cell_multilinear_weight_top_test.sv =====
`timescale 1ns / 1ps
module grid_cell_multilinear_weight_top_test;
  import gcmw_pkg::*;

  localparam int DIMENSION  = 3;
  localparam int AXIS_CELLS = 1024;
  localparam int FRAC_BITS  = 16;
  localparam longint UNIT   = longint'(1) << FRAC_BITS;

  // pipeline depth, with some slack on top
  localparam int SETTLE_CYCLES   = FRAC_BITS + 48;
  // cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT     = 2000;
  localparam int WORDS_PER_PHASE = 125;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  coord_t             point_x   = '0;
  coord_t             point_y   = '0;
  coord_t             point_z   = '0;
  cell_t              cell_x    = '0;
  cell_t              cell_y    = '0;
  cell_t              cell_z    = '0;
  corner_t            corner    = '0;
  logic               cfg_we    = 1'b0;
  reg_idx_t           cfg_index = REG_ORIGIN_X;
  logic [COORD_W-1:0] cfg_data  = '0;
  logic               busy;
  logic               done;
  logic [FRAC_BITS:0] weight;

  int outstanding;
  int failures;
  int stall_cycles = 0;
  // percent chance of inserting one more idle cycle before a word
  int idle_pct = 35;

  // current grid settings, only used to aim points into the addressed cell
  longint aim_origin [MAX_AXES] = '{0, 0, 0};
  longint aim_len [MAX_AXES]    = '{65536, 65536, 65536};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  grid_cell_multilinear_weight_top #(
    .DIMENSION (DIMENSION),
    .AXIS_CELLS(AXIS_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .cell_z   (cell_z),
    .corner   (corner),
    .done     (done),
    .weight   (weight),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // prediction and comparison live in the checker, the top only drives
  grid_cell_multilinear_weight_check #(
    .DIMENSION (DIMENSION),
    .AXIS_CELLS(AXIS_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) weight_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .corner     (corner),
    .done       (done),
    .weight     (weight),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .failures   (failures)
  );

  // watchdog: any accepted word or delivered weight restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // program all six registers back to back, block is idle here
  task automatic write_settings(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz, input logic [31:0] lx,
                                input logic [31:0] ly, input logic [31:0] lz);
    logic [31:0] vals [6];
    reg_idx_t    idx [6];
    vals = '{ox, oy, oz, lx, ly, lz};
    idx  = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
             REG_CELL_LEN_X, REG_CELL_LEN_Y, REG_CELL_LEN_Z};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    aim_origin[0] = longint'(signed'(ox));
    aim_origin[1] = longint'(signed'(oy));
    aim_origin[2] = longint'(signed'(oz));
    // top bit of a length write is dropped by the register
    aim_len[0] = longint'(lx[LEN_W-1:0]);
    aim_len[1] = longint'(ly[LEN_W-1:0]);
    aim_len[2] = longint'(lz[LEN_W-1:0]);
  endtask

  // one command word; called right after a rising edge, returns right after
  // the edge that took it
  task automatic issue_word(input coord_t px, input coord_t py, input coord_t pz,
                            input cell_t cx, input cell_t cy, input cell_t cz,
                            input corner_t cn);
    int gap;
    bit taken;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    cell_x  <= cx;
    cell_y  <= cy;
    cell_z  <= cz;
    corner  <= cn;
    // busy is looked at mid-cycle so the handshake never races the edge
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // stop sending and wait for every predicted weight to come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // point that lands inside the chosen cell, edges favored, with a
  // one-lsb wobble around the floor boundaries
  function automatic coord_t aimed_coord(input int axis, output cell_t cx);
    longint len, reach, u, frac;
    int wobble;
    len = (aim_len[axis] == 0) ? 64'sd1 : aim_len[axis];
    reach = longint'(32'h7fff_ffff) / len;
    if (reach > AXIS_CELLS - 1) reach = AXIS_CELLS - 1;
    cx = cell_t'($urandom_range(0, int'(reach)));
    case ($urandom_range(0, 5))
      0:       frac = 0;
      1:       frac = UNIT;
      2:       frac = $urandom_range(0, 255);
      3:       frac = UNIT - $urandom_range(0, 255);
      default: frac = $urandom_range(0, 32'(UNIT));
    endcase
    wobble = int'($urandom_range(0, 2)) - 1;
    u = longint'(cx) * UNIT + frac;
    return coord_t'(aim_origin[axis] + ((u * len) >>> FRAC_BITS) + longint'(wobble));
  endfunction

  // mostly well-aimed points, some with a mismatched cell, some pure noise
  task automatic random_word();
    coord_t p [MAX_AXES];
    cell_t  c [MAX_AXES];
    int     mode;
    mode = $urandom_range(0, 99);
    for (int a = 0; a < MAX_AXES; a++) begin
      if (mode < 85) p[a] = aimed_coord(a, c[a]);
      else p[a] = coord_t'($urandom);
      if (mode >= 70) c[a] = cell_t'($urandom);
    end
    issue_word(p[0], p[1], p[2], c[0], c[1], c[2], corner_t'($urandom));
  endtask

  // random grid: origins near zero or anywhere, lengths over all magnitudes,
  // now and then a zero length, junk in the unused top bit
  task automatic random_settings();
    logic [31:0] o [MAX_AXES];
    logic [31:0] l [MAX_AXES];
    for (int a = 0; a < MAX_AXES; a++) begin
      if ($urandom_range(0, 1)) o[a] = $urandom;
      else o[a] = 32'($urandom_range(0, 2**21)) - 32'(2**20);
      l[a] = $urandom_range(1, 32'h1 << $urandom_range(0, 30));
      if ($urandom_range(0, 15) == 0) l[a] = '0;
      l[a][31] = $urandom_range(0, 1);
    end
    write_settings(o[0], o[1], o[2], l[0], l[1], l[2]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset grid: unit cells at the origin
    // every corner of one interior point
    for (int k = 0; k < 8; k++)
      issue_word(32'h0000_4000, 32'h0000_8000, 32'h0000_c000, '0, '0, '0, corner_t'(k));
    // point on the near corner itself
    issue_word('0, '0, '0, '0, '0, '0, 3'd0);
    issue_word('0, '0, '0, '0, '0, '0, 3'd7);
    // far outside on both sides, largest cells
    issue_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 10'h3ff, 10'h3ff, 10'h3ff, 3'd7);
    issue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, 3'd0);
    issue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'h3ff, 10'h3ff, 10'h3ff, 3'd7);
    // on a cell face from either side, and mid-cell in the last cell
    issue_word(32'h0005_0000, 32'h0005_0000, 32'h03ff_8000, 10'd5, 10'd4, 10'h3ff, 3'd3);
    // one lsb below zero, one lsb below one, exactly one
    issue_word(32'hffff_ffff, 32'h0000_ffff, 32'h0001_0000, '0, '0, '0, 3'd6);
    // alternating bit patterns
    issue_word(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 10'h155, 10'h2aa, '0, 3'd5);
    repeat (130) random_word();
    drain();

    // lowest origins, zero and minimum cell lengths
    write_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h0000_0000, 32'h0000_0001, 32'h8000_0001);
    repeat (WORDS_PER_PHASE) random_word();
    drain();

    // highest origins, longest cells on x and y, length 65536 on z
    write_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'hffff_ffff, 32'h0001_0000);
    repeat (WORDS_PER_PHASE) random_word();
    drain();

    // random grids; the second one runs back to back with no idle cycles
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph == 1) ? 0 : 35;
      random_settings();
      repeat (WORDS_PER_PHASE) random_word();
      drain();
    end

    // catch any stray weight after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
